### sv/postfix_expression_evaluator_core_assert.svh
// assertion macros for the postfix evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define PEV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication into the next cycle
`define PEV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pev_pkg.sv
// ----------------------------------------------------------------------------
// pev_pkg
// types and constants for the postfix evaluator core
// ----------------------------------------------------------------------------
package pev_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_W          = 32;
    localparam int NUM_W           = 31;

    localparam logic [1:0] ACT_NUMBER = 2'd0;
    localparam logic [1:0] ACT_OPER   = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FEW       = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_UNSUP     = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

endpackage

### sv/postfix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// reverse polish evaluator with a ram operand stack and a serial divider
// ----------------------------------------------------------------------------
// One token per transfer; one result per token. A number makes no ram read; an
// end item makes one ram read of the bottom entry; add, subtract and multiply
// make two ram reads of the stack top, then write back; and divide runs the
// radix-2 divider that retires one quotient bit per cycle. Items are handled
// one at a time; the result sits in an output register and the next token is
// taken once it has gone.
`include "postfix_expression_evaluator_core_assert.svh"

module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = pev_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [pev_pkg::NUM_W-1:0]   i_number_value,
    input  logic [2:0]                  i_operator_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic signed [pev_pkg::WORD_W-1:0] o_result_value,
    output logic                        o_done_res
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int W  = pev_pkg::WORD_W;
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    pev_pkg::t_state r_state, n_state;
    logic [DW-1:0]   r_depth, n_depth;
    logic [2:0]      r_err, n_err;
    logic [1:0]      r_act;
    logic [W-1:0]    r_num;
    logic [2:0]      r_code;
    logic [W-1:0]    r_b, r_a;
    logic [W-1:0]    r_res;
    logic            r_ovalid;
    logic [2:0]      r_status;
    logic [W-1:0]    r_value;
    logic            r_done;
    logic [5:0]      r_cnt;
    logic [W-1:0]    r_quo, r_rem, r_dvs;
    logic            r_neg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [W-1:0]    ram_wdata, ram_rdata;

    logic            accept;
    logic [W:0]      rem_sh;
    logic [W:0]      rem_sub;

    pev_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready = (r_state == pev_pkg::S_IDLE) && !r_ovalid;
    assign accept  = i_valid && o_ready;
    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_result_value = r_value;
    assign o_done_res     = r_done;

    assign rem_sh  = {r_rem, r_quo[W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pev_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_action == pev_pkg::ACT_OPER && i_operator_code <= pev_pkg::OP_DIV
                        && r_err == pev_pkg::ST_OK && r_depth >= DW'(2)) begin
                        n_state = pev_pkg::S_RD1;
                    end else if (i_action == pev_pkg::ACT_END) begin
                        n_state = pev_pkg::S_RD1;
                    end else begin
                        n_state = pev_pkg::S_OUT;
                    end
                end
            end
            pev_pkg::S_RD1: n_state = (r_act == pev_pkg::ACT_END) ? pev_pkg::S_OUT
                                                                  : pev_pkg::S_RD2;
            pev_pkg::S_RD2: n_state = pev_pkg::S_EXEC;
            pev_pkg::S_EXEC: begin
                if (r_code == pev_pkg::OP_DIV && r_b != '0) begin
                    n_state = pev_pkg::S_DIV;
                end else begin
                    n_state = pev_pkg::S_OUT;
                end
            end
            pev_pkg::S_DIV:  n_state = (r_cnt == 6'd0) ? pev_pkg::S_WB : pev_pkg::S_DIV;
            pev_pkg::S_WB:   n_state = pev_pkg::S_OUT;
            pev_pkg::S_OUT:  n_state = pev_pkg::S_IDLE;
            default:         n_state = pev_pkg::S_IDLE;
        endcase
    end

    // ram access, depth and latch updates
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_depth[AW-1:0];
        ram_wdata = r_num;
        ram_raddr = '0;
        n_depth   = r_depth;
        n_err     = r_err;
        case (r_state)
            pev_pkg::S_IDLE: begin
                if (accept && i_action != pev_pkg::ACT_END && r_err == pev_pkg::ST_OK) begin
                    if (i_action == pev_pkg::ACT_NUMBER) begin
                        if (r_depth >= FULL) begin
                            n_err = pev_pkg::ST_OVERFLOW;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_depth[AW-1:0];
                            ram_wdata = {1'b0, i_number_value};
                            n_depth   = r_depth + DW'(1);
                        end
                    end else if (i_action == pev_pkg::ACT_OPER) begin
                        if (r_depth < DW'(2)) begin
                            n_err = pev_pkg::ST_FEW;
                        end else if (i_operator_code > pev_pkg::OP_DIV) begin
                            n_err   = pev_pkg::ST_UNSUP;
                            n_depth = r_depth - DW'(2);
                        end
                    end
                end
                // stack top first, bottom entry for an end item
                ram_raddr = (i_action == pev_pkg::ACT_END) ? '0
                                                           : AW'(r_depth - DW'(1));
            end
            pev_pkg::S_RD1: ram_raddr = AW'(r_depth - DW'(2));
            pev_pkg::S_EXEC: begin
                n_depth = r_depth - DW'(2);
                if (r_code == pev_pkg::OP_DIV && r_b == '0) begin
                    n_err = pev_pkg::ST_DIVZERO;
                end else if (r_code != pev_pkg::OP_DIV) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_depth - DW'(2));
                    ram_wdata = r_res;
                    n_depth   = r_depth - DW'(1);
                end
            end
            pev_pkg::S_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_depth[AW-1:0];
                ram_wdata = r_neg ? (W'(0) - r_quo) : r_quo;
                n_depth   = r_depth + DW'(1);
            end
            pev_pkg::S_OUT: begin
                if (r_act == pev_pkg::ACT_END) begin
                    n_depth = '0;
                    n_err   = pev_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pev_pkg::S_IDLE;
            r_depth  <= '0;
            r_err    <= pev_pkg::ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_err   <= n_err;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end else if (r_state == pev_pkg::S_OUT) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        case (r_state)
            pev_pkg::S_IDLE: begin
                if (accept) begin
                    r_act  <= i_action;
                    r_num  <= {1'b0, i_number_value};
                    r_code <= i_operator_code;
                end
            end
            pev_pkg::S_RD1: r_b <= ram_rdata;
            pev_pkg::S_RD2: begin
                r_a <= ram_rdata;
                case (r_code)
                    pev_pkg::OP_ADD: r_res <= ram_rdata + r_b;
                    pev_pkg::OP_SUB: r_res <= ram_rdata - r_b;
                    pev_pkg::OP_MUL: r_res <= W'(ram_rdata * r_b);
                    default:         r_res <= '0;
                endcase
            end
            pev_pkg::S_EXEC: begin
                r_quo <= r_a[W-1] ? (W'(0) - r_a) : r_a;
                r_dvs <= r_b[W-1] ? (W'(0) - r_b) : r_b;
                r_neg <= r_a[W-1] ^ r_b[W-1];
                r_rem <= '0;
                r_cnt <= 6'(W - 1);
            end
            pev_pkg::S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!rem_sub[W]) begin
                    r_rem <= rem_sub[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            pev_pkg::S_OUT: begin
                r_done <= (r_act == pev_pkg::ACT_END);
                r_value <= '0;
                if (r_act == pev_pkg::ACT_END) begin
                    if (r_err != pev_pkg::ST_OK) begin
                        r_status <= r_err;
                    end else if (r_depth != DW'(1)) begin
                        r_status <= pev_pkg::ST_MALFORMED;
                    end else begin
                        r_status <= pev_pkg::ST_OK;
                        r_value  <= r_b;
                    end
                end else begin
                    r_status <= r_err;
                end
            end
            default: ;
        endcase
    end

    `PEV_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= FULL,
        "stack depth beyond capacity")
    `PEV_ASSERT(a_no_accept_busy, i_clk, i_rst_n,
        !(accept && r_state != pev_pkg::S_IDLE), "transfer taken while busy")
    `PEV_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n,
        r_state == pev_pkg::S_OUT && r_act == pev_pkg::ACT_END,
        r_depth == '0 && r_err == pev_pkg::ST_OK, "end item left state behind")
    `PEV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !i_ready,
        r_ovalid && $stable(r_status), "result dropped while stalled")

endmodule

### sv/pev_ram.sv
// ----------------------------------------------------------------------------
// pev_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module pev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
